// ----- hdl/gmi_pkg.sv -----
// Package: widths, action and status codes, state machine support for the interpolator.
`timescale 1ns / 1ps
package gmi_pkg;
    localparam int MAP_ENTRIES_DEF      = 4096;
    localparam int CM_FRACTION_BITS_DEF = 16;

    localparam logic [2:0] ACT_LOAD    = 3'd0;
    localparam logic [2:0] ACT_CM_AT   = 3'd1;
    localparam logic [2:0] ACT_BETWEEN = 3'd2;
    localparam logic [2:0] ACT_LEAST   = 3'd3;
    localparam logic [2:0] ACT_GREAT   = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ABSENT = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_DIFFER = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  chromosome;
        logic [31:0] position_bp;
        logic [4:0]  chromosome_2;
        logic [31:0] position_bp_2;
        logic [31:0] map_cm;
    } t_req;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch request
        logic write;      // store load point
        logic scan_start; // clear scan state, index 0, key select
        logic sel_second; // key is position_bp_2 at scan_start; alone, build response value
        logic read;       // issue memory read at scan index
        logic eval;       // evaluate registered read data
        logic div_start;
        logic save_a;     // hold first cM of a between query
        logic finish;     // resolve a scan that ended without a hit
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       full;
        logic       scan_end;  // index reached count
        logic       hit;       // evaluated point decides the scan
        logic       need_div;
        logic       div_done;
        logic       absent;
    } t_stat;
endpackage

// ----- hdl/gmi_if.sv -----
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface gmi_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gmi_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module gmi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_sh;

    assign o_quot = r_q[31:0];
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign w_sh   = {r_rem[31:0], r_q[63]};

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = 7'd64; n_busy = 1'b1;
        end else if (r_busy && r_cnt != 7'd0) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
        end else if (r_busy) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end
endmodule

// ----- hdl/gmi_datapath.sv -----
// Datapath: point memory, scan registers, bracket selection and interpolation.
`timescale 1ns / 1ps
module gmi_datapath #(
    parameter int MAP_ENTRIES      = gmi_pkg::MAP_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gmi_pkg::t_req i_req,
    input  gmi_pkg::t_cmd i_cmd,
    output gmi_pkg::t_stat o_stat,
    output gmi_pkg::t_rsp o_rsp
);
    import gmi_pkg::*;
    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CW = $clog2(MAP_ENTRIES + 1);

    logic [68:0] mem [MAP_ENTRIES];
    logic [68:0] r_rd;
    logic [CW-1:0] r_count, r_idx;
    t_req r_req;
    logic [2:0] r_status;
    logic [31:0] r_value, r_a, r_key;
    logic r_have_prev, r_hit_first, r_mode_bp;
    logic [31:0] r_prev_bp, r_prev_cm;
    logic [31:0] r_x1, r_y1, r_x2, r_y2, r_x;
    logic r_need_div, r_dir_up;
    logic [31:0] r_direct;
    logic        w_dv_done;
    logic [31:0] w_quot;
    logic [31:0] w_span, w_dy, w_dx, w_xc;

    wire [4:0]  rd_chr = r_rd[68:64];
    wire [31:0] rd_bp  = r_rd[63:32];
    wire [31:0] rd_cm  = r_rd[31:0];
    wire strict = (r_req.action == ACT_GREAT);
    wire mine   = (rd_chr == r_req.chromosome);
    logic hit;

    always_comb begin
        if (!r_mode_bp) hit = mine && (rd_bp >= r_key);
        else if (strict) hit = mine && (rd_cm > r_key);
        else hit = mine && (rd_cm >= r_key);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write)
            mem[r_count[AW-1:0]] <= {r_req.chromosome, r_req.position_bp, r_req.map_cm};
        if (i_cmd.read)
            r_rd <= mem[r_idx[AW-1:0]];
    end

    // bracket values for lerp (x1,y1,x2,y2,x)
    always_comb begin
        w_xc = r_x;
        if (w_xc < r_x1) w_xc = r_x1;
        if (w_xc > r_x2) w_xc = r_x2;
        w_span = r_x2 - r_x1;
        w_dx   = w_xc - r_x1;
        w_dy   = r_dir_up ? (r_y2 - r_y1) : (r_y1 - r_y2);
    end

    logic [63:0] r_prod;
    logic        r_mul_go;
    gmi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mul_go),
        .i_num(r_prod), .i_den(w_span), .o_done(w_dv_done), .o_quot(w_quot)
    );

    wire [31:0] lerp_res = r_dir_up ? (r_y1 + w_quot) : (r_y1 - w_quot);

    assign o_stat.full     = (r_count == CW'(MAP_ENTRIES));
    assign o_stat.scan_end = (r_idx == r_count);
    assign o_stat.hit      = hit;
    assign o_stat.need_div = r_need_div;
    assign o_stat.div_done = w_dv_done;
    assign o_stat.absent   = (r_status != ST_OK);
    assign o_rsp.value  = r_value;
    assign o_rsp.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mul_go <= 1'b0;
        end else begin
            r_mul_go <= i_cmd.div_start;
            if (i_cmd.write) r_count <= r_count + CW'(1);
        end
        if (i_cmd.capture) begin
            r_req <= i_req;
            if (i_req.action == ACT_BETWEEN && i_req.chromosome != i_req.chromosome_2)
                r_status <= ST_DIFFER;
            else if (i_req.action == ACT_LOAD && o_stat.full)
                r_status <= ST_FULL;
            else
                r_status <= ST_OK;
            r_value <= '0;
        end
        if (i_cmd.div_start) r_prod <= 64'(w_dy) * 64'(w_dx);
        if (i_cmd.scan_start) begin
            r_idx <= '0;
            r_have_prev <= 1'b0;
            r_mode_bp <= (r_req.action == ACT_LEAST) || (r_req.action == ACT_GREAT);
            r_key <= (r_req.action == ACT_LEAST || r_req.action == ACT_GREAT) ? r_req.map_cm :
                     (i_cmd.sel_second ? r_req.position_bp_2 : r_req.position_bp);
            r_need_div <= 1'b0;
        end
        if (i_cmd.read) r_idx <= r_idx + CW'(1);
        if (i_cmd.save_a) r_a <= r_direct;
        if (i_cmd.eval) begin
            if (hit) begin
                if (!r_mode_bp) begin
                    r_x1 <= r_prev_bp; r_y1 <= r_prev_cm;
                    r_x2 <= rd_bp;     r_y2 <= rd_cm; r_x <= r_key;
                    r_dir_up <= rd_cm > r_prev_cm;
                    if (!r_have_prev) r_direct <= rd_cm;
                    else if (r_prev_cm == rd_cm) r_direct <= rd_cm;
                    else if (rd_bp <= r_prev_bp) r_direct <= r_prev_cm;
                    else r_need_div <= 1'b1;
                end else begin
                    r_x1 <= r_prev_cm; r_y1 <= r_prev_bp;
                    r_x2 <= rd_cm;     r_y2 <= rd_bp; r_x <= r_key;
                    r_dir_up <= rd_bp > r_prev_bp;
                    if (!r_have_prev) begin
                        r_direct <= rd_bp;
                        if (strict || rd_cm > r_key) r_status <= ST_RANGE;
                    end else if (rd_cm == r_key) r_direct <= rd_bp;
                    else if (r_prev_bp == rd_bp) r_direct <= rd_bp;
                    else if (rd_cm <= r_prev_cm) r_direct <= r_prev_bp;
                    else r_need_div <= 1'b1;
                end
            end else if (mine) begin
                r_have_prev <= 1'b1;
                r_prev_bp <= rd_bp; r_prev_cm <= rd_cm;
            end
        end
        if (i_cmd.finish) begin
            // scan ran out without a hit: resolved here
            if (o_stat.scan_end && !r_hit_first) begin
                if (!r_have_prev) r_status <= ST_ABSENT;
                else if (r_mode_bp) r_status <= ST_RANGE;
                else r_direct <= r_prev_cm;
            end
        end
        if (w_dv_done) r_direct <= lerp_res;
        if (i_cmd.capture) r_hit_first <= 1'b0;
        if (i_cmd.scan_start) r_hit_first <= 1'b0;
        if (i_cmd.eval && hit) r_hit_first <= 1'b1;
        if (i_cmd.sel_second && !i_cmd.scan_start && r_status == ST_OK) begin
            // final step of a query: value from direct (and a for between)
            if (r_req.action == ACT_BETWEEN)
                r_value <= (r_direct >= r_a) ? r_direct - r_a : '0;
            else
                r_value <= r_direct;
        end
    end
endmodule

// ----- hdl/gmi_ctrl.sv -----
// Controller: sequences load, scans, interpolation and the response.
`timescale 1ns / 1ps
module gmi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [2:0]     i_action,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  gmi_pkg::t_stat i_stat,
    output gmi_pkg::t_cmd  o_cmd
);
    import gmi_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_START = 4'd2, S_RD = 4'd3,
                           S_WAIT = 4'd4, S_EVAL = 4'd5, S_DIV = 4'd6, S_DIVW = 4'd7,
                           S_END = 4'd8, S_VAL = 4'd9, S_OUT = 4'd10;
    logic [3:0] r_state, n_state;
    logic [2:0] r_act;
    logic       r_second, n_second;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_second = r_second;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin o_cmd.capture = 1'b1; n_state = S_DISP; end
            S_DISP: begin
                n_second = 1'b0;
                if (i_stat.absent) n_state = S_OUT;
                else if (r_act == ACT_LOAD) begin
                    o_cmd.write = 1'b1; n_state = S_OUT;
                end else if (r_act >= ACT_CM_AT && r_act <= ACT_GREAT) n_state = S_START;
                else n_state = S_OUT;
            end
            S_START: begin
                o_cmd.scan_start = 1'b1; o_cmd.sel_second = r_second; n_state = S_RD;
            end
            S_RD: begin
                if (i_stat.scan_end) begin o_cmd.finish = 1'b1; n_state = S_END; end
                else begin o_cmd.read = 1'b1; n_state = S_WAIT; end
            end
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.hit ? S_DIV : S_RD;
            end
            S_DIV: begin
                if (i_stat.absent) n_state = S_OUT;
                else if (i_stat.need_div) begin o_cmd.div_start = 1'b1; n_state = S_DIVW; end
                else n_state = S_END;
            end
            S_DIVW: if (i_stat.div_done) n_state = S_END;
            S_END: begin
                if (i_stat.absent) n_state = S_OUT;
                else if (r_act == ACT_BETWEEN && !r_second) begin
                    o_cmd.save_a = 1'b1; n_second = 1'b1; n_state = S_START;
                end else n_state = S_VAL;
            end
            S_VAL: begin o_cmd.sel_second = 1'b1; n_state = S_OUT; end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state <= n_state;
            r_second <= n_second;
        end
        if (o_cmd.capture) r_act <= i_action;
    end
endmodule

// ----- hdl/genetic_map_interpolator_top.sv -----
// Top level of the genetic map interpolator.
`timescale 1ns / 1ps
// Genetic map interpolator: piecewise linear table of map points.
// Input channel i_req carries one request: action, chromosome, position_bp,
// chromosome_2, position_bp_2, map_cm. Output channel o_rsp returns one
// response per request: value and status.
// A query scans the stored points linearly (all chromosomes), reading
// each point up to the bracketing point; with interpolation the 64-step
// shift and subtract divider runs after the scan. A between query scans
// twice. One request is handled at a time.
// The response is held in a register until the receiver takes it; the
// input is not ready until the response has been delivered, so a stall on
// the output holds the block.
// Reset (i_rst_n low, synchronous) empties the table (count to zero) and
// returns the controller to idle; stored points need no clearing.
// Loads beyond MAP_ENTRIES are dropped with status table full.
module genetic_map_interpolator_top #(
    parameter int MAP_ENTRIES      = gmi_pkg::MAP_ENTRIES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    gmi_if.sink   i_req,
    gmi_if.source o_rsp
);
    import gmi_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;
    t_req  w_req;
    t_rsp  w_rsp;

    assign w_req = i_req.data;
    assign o_rsp.data = w_rsp;

    gmi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready), .i_action(w_req.action),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    gmi_datapath #(.MAP_ENTRIES(MAP_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_rsp(w_rsp)
    );
endmodule
